/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rate limiter rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/srl_pkg.sv */
// shared types, codes and constants of the source reputation rate limiter
// no dependencies; imported by every module of the block
package srl_pkg;

    // score limits
    localparam logic signed [15:0] SCORE_MIN = -16'sd3000;
    localparam logic signed [15:0] SCORE_MAX = 16'sd100;

    // request kinds
    localparam logic [2:0] FN_ADJUST    = 3'd0;
    localparam logic [2:0] FN_DIRECT    = 3'd1;
    localparam logic [2:0] FN_RELAY     = 3'd2;
    localparam logic [2:0] FN_SET       = 3'd3;
    localparam logic [2:0] FN_RESET     = 3'd4;
    localparam logic [2:0] FN_RESET_ALL = 3'd5;

    // result status codes
    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_REJECT = 2'd2;

    // configuration register indexes
    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] CFG_IMPROVE_INTERVAL = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_IMPROVE_STEP     = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_ATTEMPT_PENALTY  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_ACCEPT_THRESHOLD = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_DIRECT_INTERVAL  = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_DIRECT_MAX       = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_RELAY_INTERVAL   = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_RELAY_MAX        = 3'd7;

    typedef struct packed {
        logic [15:0]        improve_interval;
        logic [11:0]        improve_step;
        logic [11:0]        attempt_penalty;
        logic signed [15:0] accept_threshold;
        logic [15:0]        direct_interval;
        logic [15:0]        direct_max;
        logic [15:0]        relay_interval;
        logic [15:0]        relay_max;
    } srl_cfg_t;

    // fixed result loads requested by the controller
    typedef enum logic [1:0] {
        RES_NONE,
        RES_REJECT,
        RES_FULL,
        RES_CLEAR
    } srl_res_t;

    typedef struct packed {
        logic     load;
        logic     scan;
        logic     insert;
        logic     read;
        logic     load_work;
        logic     f_one;
        logic     div_start;
        logic     f_div;
        logic     mul;
        logic     credit;
        logic     exec;
        logic     sweep;
        logic     push;
        srl_res_t res;
    } srl_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       hit;
        logic       scan_end;
        logic       free_any;
        logic       scan_last;
        logic       imp_need;
        logic       ivl_zero;
        logic       div_done;
        logic       out_space;
    } srl_sts_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_INSERT,
        S_READ,
        S_LOAD,
        S_ADJ,
        S_DIV,
        S_MUL,
        S_CREDIT,
        S_EXEC,
        S_SWEEP,
        S_PUSH
    } srl_state_t;

    typedef struct packed {
        logic signed [15:0] score;
        logic [31:0]        stamp;
    } srl_rep_t;

    typedef struct packed {
        logic [15:0] dcnt;
        logic [31:0] dstamp;
        logic [15:0] rcnt;
        logic [31:0] rstamp;
    } srl_att_t;

    // saturate a widened score into the legal range
    function automatic logic signed [15:0] clamp_score(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v > SCORE_MAX)
            r = SCORE_MAX;
        else if (v < SCORE_MIN)
            r = SCORE_MIN;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

/* hw/rtl/srl_cfg.sv */
// configuration register bank of the rate limiter
// depends on srl_pkg
module srl_cfg
    import srl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [15:0]       cfg_wdata,
    output srl_cfg_t          cfg
);

    srl_cfg_t cfg_reg, cfg_next;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_IMPROVE_INTERVAL: cfg_next.improve_interval = cfg_wdata;
                CFG_IMPROVE_STEP:     cfg_next.improve_step     = cfg_wdata[11:0];
                CFG_ATTEMPT_PENALTY:  cfg_next.attempt_penalty  = cfg_wdata[11:0];
                CFG_ACCEPT_THRESHOLD: cfg_next.accept_threshold = $signed(cfg_wdata);
                CFG_DIRECT_INTERVAL:  cfg_next.direct_interval  = cfg_wdata;
                CFG_DIRECT_MAX:       cfg_next.direct_max       = cfg_wdata;
                CFG_RELAY_INTERVAL:   cfg_next.relay_interval   = cfg_wdata;
                CFG_RELAY_MAX:        cfg_next.relay_max        = cfg_wdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.improve_interval <= 16'd300;
            cfg_reg.improve_step     <= 12'd1;
            cfg_reg.attempt_penalty  <= 12'd20;
            cfg_reg.accept_threshold <= 16'sd0;
            cfg_reg.direct_interval  <= 16'd10;
            cfg_reg.direct_max       <= 16'd2;
            cfg_reg.relay_interval   <= 16'd10;
            cfg_reg.relay_max        <= 16'd2;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/srl_div.sv */
// radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle
// depends on srl_pkg only for the house import
module srl_div
    import srl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [16:0] shifted;
    logic        fits;

    // one quotient bit per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[31]};
        fits      = shifted >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = 16'd0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? 16'(shifted - {1'b0, dvs_reg}) : shifted[15:0];
            quo_next = {quo_reg[30:0], fits};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/srl_dp.sv */
// datapath of the rate limiter: source table memories, search, arithmetic, result register
// depends on srl_pkg, srl_div and assert_macros.svh
`include "assert_macros.svh"
module srl_dp
    import srl_pkg::*;
#(
    parameter int ENTRIES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  srl_cfg_t           cfg,
    input  srl_cmd_t           cmd,
    output srl_sts_t           sts,
    input  logic [2:0]         func,
    input  logic [63:0]        addr_hi,
    input  logic [63:0]        addr_lo,
    input  logic [31:0]        now_s,
    input  logic signed [15:0] delta,
    input  logic signed [15:0] set_score,
    input  logic signed [31:0] age_s,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [1:0]         status,
    output logic signed [15:0] score,
    output logic               acceptable
);

    localparam int IDXW = $clog2(ENTRIES);
    localparam logic [IDXW-1:0] LAST = IDXW'(ENTRIES - 1);

    // table storage
    logic [127:0] key_mem [ENTRIES];
    srl_rep_t     rep_mem [ENTRIES];
    srl_att_t     att_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;

    // request fields
    logic [2:0]         func_reg;
    logic [127:0]       key_reg;
    logic [31:0]        now_reg;
    logic signed [15:0] delta_reg, nsc_reg;
    logic signed [31:0] age_reg;

    // search state
    logic [IDXW-1:0] scan_idx_reg, cmp_idx_reg, free_idx_reg, slot_reg;
    logic            cmp_live_reg, free_found_reg;
    logic [127:0]    key_rd_reg;
    srl_rep_t        rep_rd_reg;
    srl_att_t        att_rd_reg;

    // working values
    logic signed [15:0] wscore_reg;
    logic [31:0]        wstamp_reg, f_reg;
    logic [43:0]        prod_reg;

    // result and output registers
    logic [1:0]         res_status_reg, out_status_reg;
    logic signed [15:0] res_score_reg, out_score_reg;
    logic               res_acc_reg, out_acc_reg, out_valid_reg;

    logic               hit, cur_free, free_any;
    logic [IDXW-1:0]    free_sel;
    logic [31:0]        el_imp;
    logic               div_done;
    logic [31:0]        div_quo;
    logic signed [45:0] credit_sum;

    // execute stage signals
    logic               is_direct;
    logic [15:0]        cnt_sel, ivl_sel, mx_sel, c0, c1;
    logic [31:0]        stp_sel, s0, win_el;
    logic signed [16:0] adj_sum, pen_sum;
    logic               set_ok;
    logic signed [15:0] ex_score;
    logic [1:0]         ex_status;
    logic               ex_acc;
    logic               ex_rep_we, ex_att_we;
    srl_rep_t           ex_rep;
    srl_att_t           ex_att;

    // memory write ports
    logic            rep_we, att_we, key_we;
    logic [IDXW-1:0] rep_addr;
    srl_rep_t        rep_wdata;
    srl_att_t        att_wdata;

    // iterative divider for the improvement factor
    srl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (el_imp),
        .divisor  (cfg.improve_interval),
        .done     (div_done),
        .quotient (div_quo)
    );

    // search compare on the registered key word
    always_comb
    begin
        hit      = cmp_live_reg && valid_reg[cmp_idx_reg] && (key_rd_reg == key_reg);
        cur_free = cmp_live_reg && !valid_reg[cmp_idx_reg];
        free_any = free_found_reg || cur_free;
        free_sel = free_found_reg ? free_idx_reg : cmp_idx_reg;
    end

    // improvement arithmetic
    always_comb
    begin
        el_imp     = now_reg - wstamp_reg;
        credit_sum = $signed({{30{wscore_reg[15]}}, wscore_reg}) + $signed({2'b00, prod_reg});
    end

    // execute stage: final score update per request kind
    always_comb
    begin
        is_direct = func_reg == FN_DIRECT;
        cnt_sel   = is_direct ? att_rd_reg.dcnt : att_rd_reg.rcnt;
        stp_sel   = is_direct ? att_rd_reg.dstamp : att_rd_reg.rstamp;
        ivl_sel   = is_direct ? cfg.direct_interval : cfg.relay_interval;
        mx_sel    = is_direct ? cfg.direct_max : cfg.relay_max;
        win_el    = now_reg - stp_sel;
        c0        = (win_el >= {16'd0, ivl_sel}) ? 16'd0 : cnt_sel;
        s0        = (win_el >= {16'd0, ivl_sel}) ? now_reg : stp_sel;
        c1        = c0 + 16'd1;
        adj_sum   = {wscore_reg[15], wscore_reg} + {delta_reg[15], delta_reg};
        pen_sum   = {wscore_reg[15], wscore_reg} - $signed({5'd0, cfg.attempt_penalty});
        set_ok    = (nsc_reg >= SCORE_MIN) && (nsc_reg <= SCORE_MAX) && !age_reg[31];

        ex_score  = wscore_reg;
        ex_status = STAT_DONE;
        ex_acc    = 1'b0;
        ex_rep_we = 1'b0;
        ex_att_we = 1'b0;
        ex_rep    = '{score: wscore_reg, stamp: wstamp_reg};
        ex_att    = att_rd_reg;

        case (func_reg)
            FN_ADJUST:
            begin
                ex_score  = clamp_score(adj_sum);
                ex_rep_we = 1'b1;
            end
            FN_DIRECT, FN_RELAY:
            begin
                if (c0 == 16'hFFFF)
                begin
                    ex_status = STAT_REJECT;
                end
                else
                begin
                    ex_att_we = 1'b1;
                    if (is_direct)
                    begin
                        ex_att.dcnt   = c1;
                        ex_att.dstamp = s0;
                    end
                    else
                    begin
                        ex_att.rcnt   = c1;
                        ex_att.rstamp = s0;
                    end
                    if (c1 > mx_sel)
                    begin
                        ex_score  = clamp_score(pen_sum);
                        ex_rep_we = 1'b1;
                    end
                end
            end
            FN_SET:
            begin
                if (set_ok)
                begin
                    ex_score     = nsc_reg;
                    ex_rep.stamp = now_reg - age_reg;
                    ex_rep_we    = 1'b1;
                end
                else
                begin
                    ex_status = STAT_REJECT;
                end
            end
            FN_RESET:
            begin
                ex_score     = SCORE_MAX;
                ex_rep.stamp = now_reg;
                ex_rep_we    = 1'b1;
            end
            default:
            begin
                ex_status = STAT_REJECT;
            end
        endcase
        ex_rep.score = ex_score;

        // acceptance test
        if ((func_reg == FN_DIRECT) || (func_reg == FN_RELAY))
        begin
            if (c0 == 16'hFFFF)
                ex_acc = 1'b0;
            else if (c1 > mx_sel)
                ex_acc = ex_score >= cfg.accept_threshold;
            else
                ex_acc = 1'b1;
        end
        else
        begin
            ex_acc = ex_score >= cfg.accept_threshold;
        end
    end

    // memory write port selection
    always_comb
    begin
        key_we    = cmd.insert;
        rep_we    = 1'b0;
        att_we    = 1'b0;
        rep_addr  = slot_reg;
        rep_wdata = ex_rep;
        att_wdata = ex_att;
        if (cmd.insert)
        begin
            rep_we    = 1'b1;
            att_we    = 1'b1;
            rep_wdata = '{score: SCORE_MAX, stamp: now_reg};
            att_wdata = '{dcnt: 16'd0, dstamp: now_reg, rcnt: 16'd0, rstamp: now_reg};
        end
        else if (cmd.sweep)
        begin
            rep_we    = valid_reg[scan_idx_reg];
            rep_addr  = scan_idx_reg;
            rep_wdata = '{score: SCORE_MAX, stamp: now_reg};
        end
        else if (cmd.exec)
        begin
            rep_we = ex_rep_we;
            att_we = ex_att_we;
        end
    end

    // table memories
    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[slot_reg] <= key_reg;
        if (rep_we)
            rep_mem[rep_addr] <= rep_wdata;
        if (att_we)
            att_mem[slot_reg] <= att_wdata;
        if (cmd.scan)
            key_rd_reg <= key_mem[scan_idx_reg];
        if (cmd.read)
        begin
            rep_rd_reg <= rep_mem[slot_reg];
            att_rd_reg <= att_mem[slot_reg];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            cmp_live_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            scan_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cmp_live_reg <= cmd.scan;
            if (cmd.insert)
                valid_reg[slot_reg] <= 1'b1;
            if (cmd.load)
            begin
                scan_idx_reg   <= '0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if ((cmd.scan || cmd.sweep) && (scan_idx_reg != LAST))
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                if (cmd.scan && cur_free)
                    free_found_reg <= 1'b1;
            end
            if (cmd.push)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            key_reg   <= {addr_hi, addr_lo};
            now_reg   <= now_s;
            delta_reg <= delta;
            nsc_reg   <= set_score;
            age_reg   <= age_s;
        end
        if (cmd.scan && cur_free && !free_found_reg)
            free_idx_reg <= cmp_idx_reg;
        if (cmd.scan)
        begin
            cmp_idx_reg <= scan_idx_reg;
            if (hit)
                slot_reg <= cmp_idx_reg;
            else if (cmp_live_reg && (cmp_idx_reg == LAST))
                slot_reg <= free_sel;
        end
        if (cmd.load_work)
        begin
            wscore_reg <= rep_rd_reg.score;
            wstamp_reg <= rep_rd_reg.stamp;
        end
        if (cmd.f_one)
            f_reg <= 32'd1;
        else if (cmd.f_div)
            f_reg <= div_quo;
        if (cmd.mul)
            prod_reg <= 44'(f_reg) * 44'(cfg.improve_step);
        if (cmd.credit)
        begin
            wscore_reg <= (credit_sum > 46'(SCORE_MAX)) ? SCORE_MAX : credit_sum[15:0];
            wstamp_reg <= now_reg;
        end
        // result word
        if (cmd.exec)
        begin
            res_status_reg <= ex_status;
            res_score_reg  <= ex_score;
            res_acc_reg    <= ex_acc;
        end
        else
        begin
            case (cmd.res)
                RES_REJECT:
                begin
                    res_status_reg <= STAT_REJECT;
                    res_score_reg  <= 16'sd0;
                    res_acc_reg    <= 1'b0;
                end
                RES_FULL:
                begin
                    res_status_reg <= STAT_FULL;
                    res_score_reg  <= 16'sd0;
                    res_acc_reg    <= 1'b0;
                end
                RES_CLEAR:
                begin
                    res_status_reg <= STAT_DONE;
                    res_score_reg  <= 16'sd0;
                    res_acc_reg    <= 1'b0;
                end
                default:
                begin
                    res_status_reg <= res_status_reg;
                end
            endcase
        end
        if (cmd.push)
        begin
            out_status_reg <= res_status_reg;
            out_score_reg  <= res_score_reg;
            out_acc_reg    <= res_acc_reg;
        end
    end

    // status to the controller
    always_comb
    begin
        sts.func      = func_reg;
        sts.hit       = hit;
        sts.scan_end  = cmp_live_reg && (cmp_idx_reg == LAST);
        sts.free_any  = free_any;
        sts.scan_last = scan_idx_reg == LAST;
        sts.imp_need  = el_imp >= {16'd0, cfg.improve_interval};
        sts.ivl_zero  = cfg.improve_interval == 16'd0;
        sts.div_done  = div_done;
        sts.out_space = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign score      = out_score_reg;
    assign acceptable = out_acc_reg;

    // checks
    `ASSERT_IMPLY(a_push_space, clk, rst_n, cmd.push, !out_valid_reg || out_ready, "result pushed over a waiting word")
    `ASSERT_IMPLY(a_insert_free, clk, rst_n, cmd.insert, !valid_reg[slot_reg], "insert into an occupied slot")
    `ASSERT_NEXT(a_valid_sticky, clk, rst_n, 1'b1, (valid_reg & $past(valid_reg)) == $past(valid_reg), "slot valid bit cleared")

endmodule

/* hw/rtl/srl_ctrl.sv */
// controller state machine of the rate limiter, sequences the datapath steps
// depends on srl_pkg and assert_macros.svh
`include "assert_macros.svh"
module srl_ctrl
    import srl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  srl_sts_t sts,
    output srl_cmd_t cmd
);

    srl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res    = RES_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.func == FN_RESET_ALL)
                    state_next = S_SWEEP;
                else if (sts.func inside {FN_ADJUST, FN_DIRECT, FN_RELAY, FN_SET, FN_RESET})
                    state_next = S_SCAN;
                else
                begin
                    cmd.res    = RES_REJECT;
                    state_next = S_PUSH;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit)
                    state_next = S_READ;
                else if (sts.scan_end && sts.free_any)
                    state_next = S_INSERT;
                else if (sts.scan_end)
                begin
                    cmd.res    = RES_FULL;
                    state_next = S_PUSH;
                end
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_work = 1'b1;
                state_next    = (sts.func == FN_ADJUST) ? S_ADJ : S_EXEC;
            end
            S_ADJ:
            begin
                if (!sts.imp_need)
                    state_next = S_EXEC;
                else if (sts.ivl_zero)
                begin
                    cmd.f_one  = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.f_div  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CREDIT;
            end
            S_CREDIT:
            begin
                cmd.credit = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_PUSH;
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (sts.scan_last)
                begin
                    cmd.res    = RES_CLEAR;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (sts.out_space)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // checks
    `ASSERT_IMPLY(a_div_nonzero, clk, rst_n, cmd.div_start, !sts.ivl_zero, "divider started with zero interval")
    `ASSERT_IMPLY(a_load_ready, clk, rst_n, cmd.load, in_ready, "request loaded while not ready")
    `ASSERT_NEXT(a_push_idle, clk, rst_n, cmd.push, state_reg == S_IDLE, "no return to idle after push")

endmodule

/* hw/rtl/source_reputation_rate_limiter.sv */
// top level of the source reputation rate limiter
// depends on srl_pkg, srl_cfg, srl_dp, srl_ctrl
//
// One request word in, one result word out. The source table is searched one slot per
// cycle through a registered key memory. A found source goes on to read, load, execute and
// push; a new source is first inserted into a free slot, and a full table pushes a full
// result. An adjust may also credit improvement between load and execute: through the
// iterative divider, or with a factor of one when the improve interval is zero, then the
// multiply and credit steps. A reset-all sweeps the table and an unknown request is rejected
// without a search. A new request is taken only once the previous result has moved into
// the output register; that register holds the result until it is taken, and while it
// waits no further result can be pushed. Configuration writes are registered and take
// effect in the cycle after the enable.
module source_reputation_rate_limiter
    import srl_pkg::*;
#(
    parameter int ENTRIES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration write port
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [15:0]       cfg_wdata,
    // request stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [223:0]      s_axis_tdata,  // addr_hi, addr_lo, now_s, delta, set_score, age_s
    input  logic [2:0]        s_axis_tuser,  // func
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,  // score, acceptable, zero fill
    output logic [1:0]        m_axis_tuser   // status
);

    srl_cfg_t           cfg;
    srl_cmd_t           cmd;
    srl_sts_t           sts;
    logic signed [15:0] res_score;
    logic               res_acc;

    srl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    srl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    srl_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .sts        (sts),
        .func       (s_axis_tuser),
        .addr_hi    (s_axis_tdata[63:0]),
        .addr_lo    (s_axis_tdata[127:64]),
        .now_s      (s_axis_tdata[159:128]),
        .delta      ($signed(s_axis_tdata[175:160])),
        .set_score  ($signed(s_axis_tdata[191:176])),
        .age_s      ($signed(s_axis_tdata[223:192])),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .status     (m_axis_tuser),
        .score      (res_score),
        .acceptable (res_acc)
    );

    // result word packing
    assign m_axis_tdata = {7'd0, res_acc, res_score};

endmodule

/* tb/sv/source_reputation_rate_limiter_chk.sv */
// result checker for the source reputation rate limiter testbench
// depends on srl_pkg; watches the config port and both word streams, predicts and compares
module source_reputation_rate_limiter_chk
    import srl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [15:0]       cfg_wdata,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [223:0]      s_axis_tdata,  // addr_hi, addr_lo, now_s, delta, set_score, age_s
    input  logic [2:0]        s_axis_tuser,  // func
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [23:0]       m_axis_tdata,  // score, acceptable, zero fill
    input  logic [1:0]        m_axis_tuser,  // status
    output int                errors,
    output int                pending
);

    localparam int SLOTS = 64;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] score;
        logic        acc;
    } verdict_t;

    // shadow source table
    bit          used     [SLOTS];
    bit [63:0]   key_hi   [SLOTS];
    bit [63:0]   key_lo   [SLOTS];
    int          rep      [SLOTS];
    bit [31:0]   rep_at   [SLOTS];
    int unsigned dir_cnt  [SLOTS];
    bit [31:0]   dir_at   [SLOTS];
    int unsigned rly_cnt  [SLOTS];
    bit [31:0]   rly_at   [SLOTS];

    srl_cfg_t    cfg;
    verdict_t    awaited_results[$];

    function automatic int clip(longint v);
        if (v > SCORE_MAX) return SCORE_MAX;
        if (v < SCORE_MIN) return SCORE_MIN;
        return int'(v);
    endfunction

    // locate the source, inserting it in the first free slot; -1 when full
    function automatic int lookup_source(bit [63:0] hi, bit [63:0] lo, bit [31:0] now);
        int fr;
        fr = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (used[i]) begin
                if (key_hi[i] == hi && key_lo[i] == lo) return i;
            end
            else if (fr < 0)
                fr = i;
        end
        if (fr >= 0) begin
            used[fr] = 1; key_hi[fr] = hi; key_lo[fr] = lo;
            rep[fr] = SCORE_MAX; rep_at[fr] = now;
            dir_cnt[fr] = 0; dir_at[fr] = now; rly_cnt[fr] = 0; rly_at[fr] = now;
        end
        return fr;
    endfunction

    // apply one request to the shadow table and return the word it should produce
    function automatic verdict_t score_request(logic [2:0] fn, logic [223:0] d);
        verdict_t    v;
        bit [31:0]   now, el;
        int          dlt, nsc, age, i;
        longint      acc_v;
        longint unsigned f;
        int unsigned ivl, mx, cnt;
        bit [31:0]   stp;
        now = d[159:128];
        dlt = $signed(d[175:160]);
        nsc = $signed(d[191:176]);
        age = $signed(d[223:192]);
        v.status = STAT_DONE; v.score = '0; v.acc = 0;
        if (fn == FN_RESET_ALL) begin
            for (int k = 0; k < SLOTS; k++)
                if (used[k]) begin rep[k] = SCORE_MAX; rep_at[k] = now; end
            return v;
        end
        if (fn > FN_RESET_ALL) begin
            v.status = STAT_REJECT;
            return v;
        end
        i = lookup_source(d[63:0], d[127:64], now);
        if (i < 0) begin
            v.status = STAT_FULL;
            return v;
        end
        if (fn == FN_ADJUST) begin
            // credit whole improvement intervals first
            el = now - rep_at[i];
            if (el >= cfg.improve_interval) begin
                f = (cfg.improve_interval != 0) ? el / cfg.improve_interval : 1;
                acc_v = longint'(rep[i]) + longint'(cfg.improve_step * f);
                rep[i] = (acc_v > SCORE_MAX) ? SCORE_MAX : int'(acc_v);
                rep_at[i] = now;
            end
            rep[i] = clip(longint'(rep[i]) + dlt);
            v.acc = rep[i] >= int'(cfg.accept_threshold);
        end
        else if (fn == FN_DIRECT || fn == FN_RELAY) begin
            cnt = (fn == FN_DIRECT) ? dir_cnt[i] : rly_cnt[i];
            stp = (fn == FN_DIRECT) ? dir_at[i] : rly_at[i];
            ivl = (fn == FN_DIRECT) ? cfg.direct_interval : cfg.relay_interval;
            mx  = (fn == FN_DIRECT) ? cfg.direct_max : cfg.relay_max;
            // fixed window restart
            if (32'(now - stp) >= ivl) begin
                cnt = 0; stp = now;
            end
            if (cnt < 16'hFFFF) begin
                cnt++;
                if (cnt > mx) begin
                    rep[i] = clip(longint'(rep[i]) - longint'(cfg.attempt_penalty));
                    v.acc = rep[i] >= int'(cfg.accept_threshold);
                end
                else
                    v.acc = 1;
            end
            else
                v.status = STAT_REJECT;
            if (fn == FN_DIRECT) begin dir_cnt[i] = cnt; dir_at[i] = stp; end
            else begin rly_cnt[i] = cnt; rly_at[i] = stp; end
        end
        else if (fn == FN_SET) begin
            if (nsc < SCORE_MIN || nsc > SCORE_MAX || age < 0)
                v.status = STAT_REJECT;
            else begin
                rep[i] = nsc;
                rep_at[i] = now - d[223:192];
            end
            v.acc = rep[i] >= int'(cfg.accept_threshold);
        end
        else begin
            rep[i] = SCORE_MAX; rep_at[i] = now;
            v.acc = rep[i] >= int'(cfg.accept_threshold);
        end
        v.score = rep[i][15:0];
        return v;
    endfunction

    assign pending = awaited_results.size();

    // track config, predict on each request word, compare each result word
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t e;
        if (!rst_n) begin
            foreach (used[k]) used[k] = 0;
            cfg.improve_interval = 16'd300;
            cfg.improve_step     = 12'd1;
            cfg.attempt_penalty  = 12'd20;
            cfg.accept_threshold = 16'sd0;
            cfg.direct_interval  = 16'd10;
            cfg.direct_max       = 16'd2;
            cfg.relay_interval   = 16'd10;
            cfg.relay_max        = 16'd2;
            awaited_results.delete();
            errors = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_IMPROVE_INTERVAL: cfg.improve_interval = cfg_wdata;
                    CFG_IMPROVE_STEP:     cfg.improve_step     = cfg_wdata[11:0];
                    CFG_ATTEMPT_PENALTY:  cfg.attempt_penalty  = cfg_wdata[11:0];
                    CFG_ACCEPT_THRESHOLD: cfg.accept_threshold = cfg_wdata;
                    CFG_DIRECT_INTERVAL:  cfg.direct_interval  = cfg_wdata;
                    CFG_DIRECT_MAX:       cfg.direct_max       = cfg_wdata;
                    CFG_RELAY_INTERVAL:   cfg.relay_interval   = cfg_wdata;
                    CFG_RELAY_MAX:        cfg.relay_max        = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_results.push_back(score_request(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word status=%0d score=%0d acc=%0d",
                             $time, m_axis_tuser, $signed(m_axis_tdata[15:0]),
                             m_axis_tdata[16]);
                end
                else begin
                    e = awaited_results.pop_front();
                    if (e.status !== m_axis_tuser || e.score !== m_axis_tdata[15:0]
                        || e.acc !== m_axis_tdata[16]) begin
                        errors++;
                        $display("%0t: mismatch expected status=%0d score=%0d acc=%0d, got status=%0d score=%0d acc=%0d",
                                 $time, e.status, $signed(e.score), e.acc, m_axis_tuser,
                                 $signed(m_axis_tdata[15:0]), m_axis_tdata[16]);
                    end
                end
            end
        end
    end

endmodule

/* tb/sv/source_reputation_rate_limiter_tb.sv */
// testbench top for the source reputation rate limiter
// depends on srl_pkg, the rtl and source_reputation_rate_limiter_chk; makes stimulus, gives verdict
module source_reputation_rate_limiter_tb;
    import srl_pkg::*;

    localparam logic [2:0] FN_SPARE_LO = 3'd6;
    localparam logic [2:0] FN_SPARE_HI = 3'd7;
    localparam int IDLE_LIMIT = 20000;
    localparam int POOL = 48;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [15:0]       cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [223:0]      s_axis_tdata;  // addr_hi, addr_lo, now_s, delta, set_score, age_s
    logic [2:0]        s_axis_tuser;  // func
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [23:0]       m_axis_tdata;  // score, acceptable, zero fill
    logic [1:0]        m_axis_tuser;  // status

    int          errors;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_req;
    int          quiet_cycles;
    bit [31:0]   clock_s;
    bit [63:0]   pool_hi [POOL];
    bit [63:0]   pool_lo [POOL];

    source_reputation_rate_limiter u_top (.*);

    source_reputation_rate_limiter_chk u_chk (.*);

    // clock
    initial clk = 0;
    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // result side: random stalls plus a long hold-off on request
    always
    begin
        int seen;
        int hold_left;
        seen = 0;
        hold_left = 0;
        m_axis_tready = 0;
        forever begin
            @(negedge clk);
            if (hold_req != seen) begin
                seen = hold_req;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 0;
            end
            else
                m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else if (++quiet_cycles >= IDLE_LIMIT) begin
            $display("source_reputation_rate_limiter_tb failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we = 1; cfg_addr = idx; cfg_wdata = val;
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic send_word(logic [2:0] fn, bit [63:0] hi, bit [63:0] lo, bit [31:0] now,
                             logic [15:0] dlt, logic [15:0] nsc, logic [31:0] age);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge clk);
            s_axis_tvalid = 0;
        end
        @(negedge clk);
        s_axis_tuser = fn;
        s_axis_tdata = {age, nsc, dlt, now, lo, hi};
        s_axis_tvalid = 1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // one random request: mostly known sources with moving time
    task automatic send_random();
        int          r, p;
        bit [63:0]   hi, lo;
        logic [2:0]  fn;
        logic [15:0] nsc;
        logic [31:0] age;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 2) clock_s = $urandom;
        else clock_s += $urandom_range(0, 25);
        p = $urandom_range(0, POOL - 1);
        hi = pool_hi[p]; lo = pool_lo[p];
        if ($urandom_range(0, 99) < 6) begin
            hi = {$urandom, $urandom}; lo = {$urandom, $urandom};
        end
        fn = r < 30 ? FN_ADJUST : r < 50 ? FN_DIRECT : r < 70 ? FN_RELAY :
             r < 83 ? FN_SET : r < 93 ? FN_RESET : r < 96 ? FN_RESET_ALL :
             r < 98 ? FN_SPARE_LO : FN_SPARE_HI;
        nsc = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3100) - 3000);
        age = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 2000));
        send_word(fn, hi, lo, clock_s, 16'($urandom_range(0, 9) == 0 ? $urandom :
                  $urandom_range(0, 200) - 100), nsc, age);
    endtask

    initial
    begin
        bit [63:0] ah, al;
        rst_n = 0;
        cfg_we = 0; cfg_addr = '0; cfg_wdata = '0;
        s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = FN_ADJUST;
        send_idle_pct = 0; recv_idle_pct = 0; hold_req = 0;
        clock_s = 32'd1000;
        foreach (pool_hi[k]) begin
            pool_hi[k] = {$urandom, $urandom};
            pool_lo[k] = {$urandom, $urandom};
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, every request kind, window penalty, set limits
        ah = '1; al = '1;
        send_word(FN_RESET_ALL, '0, '0, 32'd0, '0, '0, '0);
        send_word(FN_ADJUST, ah, al, 32'd1000, 16'sd0, '0, '0);
        send_word(FN_ADJUST, ah, al, 32'd1001, 16'h7FFF, '0, '0);
        send_word(FN_ADJUST, ah, al, 32'd1002, 16'h8000, '0, '0);
        send_word(FN_ADJUST, ah, al, 32'd1902, 16'sd0, '0, '0);
        send_word(FN_DIRECT, '0, '0, 32'd1000, '0, '0, '0);
        send_word(FN_DIRECT, '0, '0, 32'd1001, '0, '0, '0);
        send_word(FN_DIRECT, '0, '0, 32'd1002, '0, '0, '0);
        send_word(FN_DIRECT, '0, '0, 32'd1020, '0, '0, '0);
        send_word(FN_RELAY, '0, '0, 32'd1003, '0, '0, '0);
        send_word(FN_RELAY, '0, '0, 32'd1004, '0, '0, '0);
        send_word(FN_RELAY, '0, '0, 32'd1005, '0, '0, '0);
        send_word(FN_SET, ah, al, 32'd2000, '0, 16'd100, 32'd0);
        send_word(FN_SET, ah, al, 32'd2000, '0, 16'd101, 32'd0);
        send_word(FN_SET, ah, al, 32'd2000, '0, -16'sd3001, 32'd0);
        send_word(FN_SET, ah, al, 32'd2000, '0, -16'sd3000, 32'h7FFFFFFF);
        send_word(FN_SET, ah, al, 32'd2000, '0, 16'd5, 32'h80000000);
        send_word(FN_SET, ah, al, 32'hFFFFFFFF, '0, 16'h8000, 32'hFFFFFFFF);
        send_word(FN_RESET, ah, al, 32'd2100, '0, '0, '0);
        send_word(FN_RESET_ALL, '0, '0, 32'd2200, '0, '0, '0);
        send_word(FN_SPARE_LO, ah, al, 32'd2300, '0, '0, '0);
        send_word(FN_SPARE_HI, ah, al, 32'd2300, '0, '0, '0);
        @(negedge clk);
        s_axis_tvalid = 0;
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_IMPROVE_INTERVAL, 16'd30); write_reg(CFG_IMPROVE_STEP, 16'd2);
                    write_reg(CFG_ATTEMPT_PENALTY, 16'd40);
                    write_reg(CFG_ACCEPT_THRESHOLD, 16'd0);
                    write_reg(CFG_DIRECT_INTERVAL, 16'd10); write_reg(CFG_DIRECT_MAX, 16'd2);
                    write_reg(CFG_RELAY_INTERVAL, 16'd15); write_reg(CFG_RELAY_MAX, 16'd3);
                    send_idle_pct = 23; recv_idle_pct = 80;
                end
                1: begin
                    write_reg(CFG_IMPROVE_INTERVAL, 16'd0); write_reg(CFG_IMPROVE_STEP, 16'hFFF);
                    write_reg(CFG_ATTEMPT_PENALTY, 16'hFFF);
                    write_reg(CFG_ACCEPT_THRESHOLD, 16'h8000);
                    write_reg(CFG_DIRECT_INTERVAL, 16'd0); write_reg(CFG_DIRECT_MAX, 16'd0);
                    write_reg(CFG_RELAY_INTERVAL, 16'hFFFF);
                    write_reg(CFG_RELAY_MAX, 16'hFFFF);
                    send_idle_pct = 80; recv_idle_pct = 23;
                end
                2: begin
                    write_reg(CFG_IMPROVE_INTERVAL, 16'hFFFF);
                    write_reg(CFG_IMPROVE_STEP, 16'd0);
                    write_reg(CFG_ATTEMPT_PENALTY, 16'd0);
                    write_reg(CFG_ACCEPT_THRESHOLD, 16'h7FFF);
                    write_reg(CFG_DIRECT_INTERVAL, 16'hFFFF);
                    write_reg(CFG_DIRECT_MAX, 16'hFFFF);
                    write_reg(CFG_RELAY_INTERVAL, 16'd0); write_reg(CFG_RELAY_MAX, 16'd0);
                    send_idle_pct = 0; recv_idle_pct = 0;
                end
                default: begin
                    write_reg(CFG_IMPROVE_INTERVAL, 16'd7); write_reg(CFG_IMPROVE_STEP, 16'd3);
                    write_reg(CFG_ATTEMPT_PENALTY, 16'd50);
                    write_reg(CFG_ACCEPT_THRESHOLD, -16'sd100);
                    write_reg(CFG_DIRECT_INTERVAL, 16'd5); write_reg(CFG_DIRECT_MAX, 16'd3);
                    write_reg(CFG_RELAY_INTERVAL, 16'd20); write_reg(CFG_RELAY_MAX, 16'd1);
                end
            endcase
            // back-pressure: hold the result side while requests keep coming
            if (ph == 2) hold_req++;
            for (int n = 0; n < 500; n++) begin
                send_random();
                // pause until every outstanding result has come back
                if (n == 250) begin
                    @(negedge clk);
                    s_axis_tvalid = 0;
                    while (pending != 0) @(posedge clk);
                end
            end
            @(negedge clk);
            s_axis_tvalid = 0;
            drain();
        end

        if (errors == 0)
            $display("source_reputation_rate_limiter_tb passed");
        else
            $display("source_reputation_rate_limiter_tb failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/srl_pkg.sv
hw/rtl/srl_cfg.sv
hw/rtl/srl_div.sv
hw/rtl/srl_dp.sv
hw/rtl/srl_ctrl.sv
hw/rtl/source_reputation_rate_limiter.sv
tb/sv/source_reputation_rate_limiter_chk.sv
tb/sv/source_reputation_rate_limiter_tb.sv
